>>> rtl/rat_acc_pkg.sv
// ----------------------------------------------------------------------------
// rat_acc_pkg
// Shared types and widths for the rational accumulator ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package rat_acc_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned OP_W       = 3;
    localparam int unsigned S_TDATA_W  = 64;
    localparam int unsigned M_TDATA_W  = 72;
    localparam int unsigned DIV_CNT_W  = $clog2(WORD_W);

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_RECIP  = 3'd5,
        OP_CMP    = 3'd6,
        OP_REDUCE = 3'd7
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_NUM,
        ST_MUL_DEN,
        ST_GCD_TEST,
        ST_GCD_DIV,
        ST_RED_NUM,
        ST_RED_DEN,
        ST_LCM_DIV,
        ST_LCM_MUL,
        ST_A_START,
        ST_A_DIV,
        ST_A_MUL,
        ST_B_DIV,
        ST_B_MUL,
        ST_COMBINE,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

>>> rtl/rational_accumulator_alu.sv
// ----------------------------------------------------------------------------
// rational_accumulator_alu
// Signed fraction accumulator with load, add, subtract, multiply, divide,
// reciprocal, compare and reduce, built around one shared radix-2 divider
// and one 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tuser = operation, s_tdata = operand
//  m_       out        m_tvalid/m_tready  m_tdata = accumulator, greater, error
//
//  load, reciprocal and requests rejected at the check go from the check
//  straight to the finish state, multiply and divide through the two multiply
//  states, reduce and add/sub/compare through the gcd remainder steps in the
//  shared divider; reduce of 0/0 is rejected after the gcd test.
//  s_tready is high only while the sequencer is idle; a finished result waits
//  in the output register while the next request is taken.
//  aresetn (synchronous) sets the accumulator to 1/1 and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_accumulator_alu (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // operand_num [31:0], operand_den [63:32]
    input  wire logic [rat_acc_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation [2:0]
    input  wire logic [rat_acc_pkg::OP_W-1:0]       s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // result_num [31:0], result_den [63:32], greater [64], error [65], zero pad
    output logic [rat_acc_pkg::M_TDATA_W-1:0]       m_tdata
);
    import rat_acc_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    word_t  on_reg, on_next, od_reg, od_next;
    word_t  acc_num_reg, acc_num_next, acc_den_reg, acc_den_next;
    word_t  ga_reg, ga_next, gb_reg, gb_next;
    word_t  lcm_reg, lcm_next, pa_reg, pa_next, pb_reg, pb_next;
    logic   err_reg, err_next, gt_reg, gt_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // shared divider
    logic                 div_start;
    word_t                div_x, div_y, div_x_mag, div_y_mag;
    logic                 div_busy_reg, div_busy_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    word_t                div_quo_reg, div_quo_next, div_rem_reg, div_rem_next;
    word_t                div_dvs_reg, div_dvs_next;
    logic                 div_negq_reg, div_negq_next, div_negr_reg, div_negr_next;
    logic [WORD_W:0]      div_shift, div_diff;
    word_t                div_q, div_r;

    // shared multiplier, low word only
    word_t                mul_x, mul_y, mul_prod;

    assign div_x_mag = div_x[WORD_W-1] ? (~div_x + 1'b1) : div_x;
    assign div_y_mag = div_y[WORD_W-1] ? (~div_y + 1'b1) : div_y;
    assign div_shift = {div_rem_reg, div_quo_reg[WORD_W-1]};
    assign div_diff  = div_shift - {1'b0, div_dvs_reg};
    assign div_q     = div_negq_reg ? (~div_quo_reg + 1'b1) : div_quo_reg;
    assign div_r     = div_negr_reg ? (~div_rem_reg + 1'b1) : div_rem_reg;
    assign mul_prod  = mul_x * mul_y;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        on_next       = on_reg;
        od_next       = od_reg;
        acc_num_next  = acc_num_reg;
        acc_den_next  = acc_den_reg;
        ga_next       = ga_reg;
        gb_next       = gb_reg;
        lcm_next      = lcm_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        err_next      = err_reg;
        gt_next       = gt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;
        div_x         = acc_num_reg;
        div_y         = gb_reg;
        mul_x         = acc_num_reg;
        mul_y         = on_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tuser);
                    on_next    = s_tdata[WORD_W-1:0];
                    od_next    = s_tdata[2*WORD_W-1:WORD_W];
                    err_next   = 1'b0;
                    gt_next    = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (od_reg == '0 && op_reg != OP_RECIP && op_reg != OP_REDUCE) begin
                    err_next   = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    unique case (op_reg) inside
                        OP_LOAD: begin
                            acc_num_next = on_reg;
                            acc_den_next = od_reg;
                            state_next   = ST_FINISH;
                        end
                        OP_ADD, OP_SUB, OP_CMP: begin
                            if (acc_den_reg == '0) begin
                                err_next   = 1'b1;
                                state_next = ST_FINISH;
                            end else begin
                                ga_next    = acc_den_reg;
                                gb_next    = od_reg;
                                state_next = ST_GCD_TEST;
                            end
                        end
                        OP_MUL, OP_DIV: begin
                            if (op_reg == OP_DIV && on_reg == '0) begin
                                err_next   = 1'b1;
                                state_next = ST_FINISH;
                            end else begin
                                state_next = ST_MUL_NUM;
                            end
                        end
                        OP_RECIP: begin
                            if (acc_num_reg == '0) begin
                                err_next = 1'b1;
                            end else begin
                                acc_num_next = acc_den_reg;
                                acc_den_next = acc_num_reg;
                            end
                            state_next = ST_FINISH;
                        end
                        OP_REDUCE: begin
                            ga_next    = acc_num_reg;
                            gb_next    = acc_den_reg;
                            state_next = ST_GCD_TEST;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_MUL_NUM: begin
                mul_x        = acc_num_reg;
                mul_y        = (op_reg == OP_DIV) ? od_reg : on_reg;
                acc_num_next = mul_prod;
                state_next   = ST_MUL_DEN;
            end
            ST_MUL_DEN: begin
                mul_x        = acc_den_reg;
                mul_y        = (op_reg == OP_DIV) ? on_reg : od_reg;
                acc_den_next = mul_prod;
                state_next   = ST_FINISH;
            end
            ST_GCD_TEST: begin
                // gcd ends when the divisor side reaches zero; gb holds it
                if (ga_reg == '0) begin
                    if (op_reg == OP_REDUCE) begin
                        if (gb_reg == '0) begin
                            err_next   = 1'b1;
                            state_next = ST_FINISH;
                        end else begin
                            div_start  = 1'b1;
                            div_x      = acc_num_reg;
                            div_y      = gb_reg;
                            state_next = ST_RED_NUM;
                        end
                    end else begin
                        div_start  = 1'b1;
                        div_x      = acc_den_reg;
                        div_y      = gb_reg;
                        state_next = ST_LCM_DIV;
                    end
                end else begin
                    div_start  = 1'b1;
                    div_x      = gb_reg;
                    div_y      = ga_reg;
                    state_next = ST_GCD_DIV;
                end
            end
            ST_GCD_DIV: begin
                if (!div_busy_reg) begin
                    gb_next    = ga_reg;
                    ga_next    = div_r;
                    state_next = ST_GCD_TEST;
                end
            end
            ST_RED_NUM: begin
                if (!div_busy_reg) begin
                    acc_num_next = div_q;
                    div_start    = 1'b1;
                    div_x        = acc_den_reg;
                    div_y        = gb_reg;
                    state_next   = ST_RED_DEN;
                end
            end
            ST_RED_DEN: begin
                if (!div_busy_reg) begin
                    acc_den_next = div_q;
                    state_next   = ST_FINISH;
                end
            end
            ST_LCM_DIV: begin
                if (!div_busy_reg) begin
                    lcm_next   = div_q;
                    state_next = ST_LCM_MUL;
                end
            end
            ST_LCM_MUL: begin
                mul_x      = lcm_reg;
                mul_y      = od_reg;
                lcm_next   = mul_prod;
                state_next = ST_A_START;
            end
            ST_A_START: begin
                div_start  = 1'b1;
                div_x      = lcm_reg;
                div_y      = acc_den_reg;
                state_next = ST_A_DIV;
            end
            ST_A_DIV: begin
                if (!div_busy_reg) begin
                    pa_next    = div_q;
                    div_start  = 1'b1;
                    div_x      = lcm_reg;
                    div_y      = od_reg;
                    state_next = ST_A_MUL;
                end
            end
            ST_A_MUL: begin
                mul_x      = acc_num_reg;
                mul_y      = pa_reg;
                pa_next    = mul_prod;
                state_next = ST_B_DIV;
            end
            ST_B_DIV: begin
                if (!div_busy_reg) begin
                    pb_next    = div_q;
                    state_next = ST_B_MUL;
                end
            end
            ST_B_MUL: begin
                mul_x      = on_reg;
                mul_y      = pb_reg;
                pb_next    = mul_prod;
                state_next = ST_COMBINE;
            end
            ST_COMBINE: begin
                if (op_reg == OP_ADD) begin
                    acc_num_next = pa_reg + pb_reg;
                    acc_den_next = lcm_reg;
                end else if (op_reg == OP_SUB) begin
                    acc_num_next = pa_reg - pb_reg;
                    acc_den_next = lcm_reg;
                end else begin
                    gt_next = ($signed(pa_reg) > $signed(pb_reg));
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W - 2*WORD_W - 2){1'b0}},
                                     err_reg, gt_reg, acc_den_reg, acc_num_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // restoring divider on magnitudes, one quotient bit per cycle
    always_comb begin
        div_busy_next = div_busy_reg;
        div_cnt_next  = div_cnt_reg;
        div_quo_next  = div_quo_reg;
        div_rem_next  = div_rem_reg;
        div_dvs_next  = div_dvs_reg;
        div_negq_next = div_negq_reg;
        div_negr_next = div_negr_reg;
        if (div_start) begin
            div_busy_next = 1'b1;
            div_cnt_next  = '0;
            div_quo_next  = div_x_mag;
            div_rem_next  = '0;
            div_dvs_next  = div_y_mag;
            div_negq_next = div_x[WORD_W-1] ^ div_y[WORD_W-1];
            div_negr_next = div_x[WORD_W-1];
        end else if (div_busy_reg) begin
            if (!div_diff[WORD_W]) begin
                div_rem_next = div_diff[WORD_W-1:0];
                div_quo_next = {div_quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                div_rem_next = div_shift[WORD_W-1:0];
                div_quo_next = {div_quo_reg[WORD_W-2:0], 1'b0};
            end
            div_cnt_next = div_cnt_reg + 1'b1;
            if (div_cnt_reg == DIV_CNT_W'(WORD_W - 1)) begin
                div_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            acc_num_reg  <= word_t'(1);
            acc_den_reg  <= word_t'(1);
            m_tvalid_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            err_reg      <= 1'b0;
            gt_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            acc_num_reg  <= acc_num_next;
            acc_den_reg  <= acc_den_next;
            m_tvalid_reg <= m_tvalid_next;
            div_busy_reg <= div_busy_next;
            div_cnt_reg  <= div_cnt_next;
            err_reg      <= err_next;
            gt_reg       <= gt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        on_reg       <= on_next;
        od_reg       <= od_next;
        ga_reg       <= ga_next;
        gb_reg       <= gb_next;
        lcm_reg      <= lcm_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        m_tdata_reg  <= m_tdata_next;
        div_quo_reg  <= div_quo_next;
        div_rem_reg  <= div_rem_next;
        div_dvs_reg  <= div_dvs_next;
        div_negq_reg <= div_negq_next;
        div_negr_reg <= div_negr_next;
    end

endmodule

`default_nettype wire

>>> rtl/rat_acc_chk.sv
// ----------------------------------------------------------------------------
// rat_acc_chk
// Port-level checks for the rational accumulator ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rat_acc_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [63:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);

    // output register is empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one request at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a rejected request never reports greater
    a_err_gt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[65] |-> !m_tdata[64])
        else $error("greater set on rejected request");

    // no result can appear in the cycle after an accept from idle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind rational_accumulator_alu rat_acc_chk u_rat_acc_chk (.*);

`default_nettype wire
